// ===== design/rmj_pkg.sv =====
// Shared constants and types for the radar measurement Jacobian pipeline.
package rmj_pkg;

	localparam int RMJ_DATA_WIDTH = 32;
	localparam int RMJ_FRAC_BITS = 16;
	localparam int RMJ_THRESH_WIDTH = 64;
	localparam logic [RMJ_THRESH_WIDTH-1:0] RMJ_MIN_RANGE_RESET = 64'd4295;

	// Output lanes of the Jacobian
	localparam int RMJ_LANES = 6;
	localparam int LANE_DRANGE_DPX = 0;
	localparam int LANE_DRANGE_DPY = 1;
	localparam int LANE_DBEARING_DPX = 2;
	localparam int LANE_DBEARING_DPY = 3;
	localparam int LANE_DRATE_DPX = 4;
	localparam int LANE_DRATE_DPY = 5;

	typedef struct packed {
		logic px_neg;
		logic py_neg;
		logic cross_neg;
		logic too_close;
		logic zero_range;
	} rmj_flags_t;

endpackage

// ===== design/rmj_sqrt_cell.sv =====
// One digit step of the pipelined integer square root, with side payload.
module rmj_sqrt_cell #(
	parameter int RW = 32,
	parameter int SW = 8
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [RW+1:0]           rem_i,
	input  logic [RW-1:0]           root_i,
	input  logic [2*RW-1:0]         val_i,
	input  logic [SW-1:0]           side_i,
	input  rmj_pkg::rmj_flags_t     flags_i,
	output logic [RW+1:0]           rem_o,
	output logic [RW-1:0]           root_o,
	output logic [2*RW-1:0]         val_o,
	output logic [SW-1:0]           side_o,
	output rmj_pkg::rmj_flags_t     flags_o
);
	import rmj_pkg::*;

	logic [RW+3:0] trial;
	logic [RW+3:0] trial_cand;
	logic [RW+3:0] diff;
	logic          ge;

	// bring down the next two bits and try root*4+1
	assign trial = {rem_i, val_i[2*RW-1 -: 2]};
	assign trial_cand = {2'b00, root_i, 2'b01};
	assign ge = trial >= trial_cand;
	assign diff = trial - trial_cand;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[RW+1:0] : trial[RW+1:0];
			root_o <= {root_i[RW-2:0], ge};
			val_o <= {val_i[2*RW-3:0], 2'b00};
			side_o <= side_i;
			flags_o <= flags_i;
		end
	end

endmodule

// ===== design/rmj_div_cell.sv =====
// One quotient bit of the pipelined restoring divider.
module rmj_div_cell #(
	parameter int DW = 32,
	parameter int LW = 32
) (
	input  logic                clk,
	input  logic                en,
	input  logic [DW-1:0]       den_i,
	input  logic [DW-1:0]       rem_i,
	input  logic [LW-1:0]       low_i,
	input  logic [LW-1:0]       q_i,
	input  logic                ovf_i,
	input  rmj_pkg::rmj_flags_t flags_i,
	output logic [DW-1:0]       den_o,
	output logic [DW-1:0]       rem_o,
	output logic [LW-1:0]       low_o,
	output logic [LW-1:0]       q_o,
	output logic                ovf_o,
	output rmj_pkg::rmj_flags_t flags_o
);
	import rmj_pkg::*;

	logic [DW:0] trial;
	logic [DW:0] diff;
	logic        ge;

	assign trial = {rem_i, low_i[LW-1]};
	assign ge = trial >= {1'b0, den_i};
	assign diff = trial - {1'b0, den_i};

	always_ff @(posedge clk) begin
		if (en) begin
			den_o <= den_i;
			rem_o <= ge ? diff[DW-1:0] : trial[DW-1:0];
			low_o <= {low_i[LW-2:0], 1'b0};
			q_o <= {q_i[LW-2:0], ge};
			ovf_o <= ovf_i;
			flags_o <= flags_i;
		end
	end

endmodule

// ===== design/rmj_div_lane.sv =====
// One divider lane: overflow check and setup stage, then a row of divider cells.
module rmj_div_lane #(
	parameter int NW = 48,
	parameter int DW = 32,
	parameter int LW = 32
) (
	input  logic                clk,
	input  logic                en,
	input  logic [NW-1:0]       num,
	input  logic [DW-1:0]       den,
	input  rmj_pkg::rmj_flags_t flags_i,
	output logic [LW-1:0]       quot,
	output logic                ovf,
	output rmj_pkg::rmj_flags_t flags_o
);
	import rmj_pkg::*;

	localparam int HW = NW - LW;
	localparam int CMW = (HW > DW) ? HW : DW;

	logic [CMW-1:0] hi_x;
	logic [CMW-1:0] den_x;

	logic [DW-1:0]    c_den   [0:LW];
	logic [DW-1:0]    c_rem   [0:LW];
	logic [LW-1:0]    c_low   [0:LW];
	logic [LW-1:0]    c_q     [0:LW];
	logic             c_ovf   [0:LW];
	rmj_flags_t       c_flags [0:LW];

	assign hi_x = CMW'(num[NW-1:LW]);
	assign den_x = CMW'(den);

	// quotient needs more than LW bits when the upper numerator reaches the divisor
	always_ff @(posedge clk) begin
		if (en) begin
			c_den[0] <= den;
			c_rem[0] <= hi_x[DW-1:0];
			c_low[0] <= num[LW-1:0];
			c_q[0] <= '0;
			c_ovf[0] <= hi_x >= den_x;
			c_flags[0] <= flags_i;
		end
	end

	for (genvar k = 0; k < LW; k++) begin : g_cell
		rmj_div_cell #(
			.DW(DW),
			.LW(LW)
		) u_cell (
			.clk    (clk),
			.en     (en),
			.den_i  (c_den[k]),
			.rem_i  (c_rem[k]),
			.low_i  (c_low[k]),
			.q_i    (c_q[k]),
			.ovf_i  (c_ovf[k]),
			.flags_i(c_flags[k]),
			.den_o  (c_den[k+1]),
			.rem_o  (c_rem[k+1]),
			.low_o  (c_low[k+1]),
			.q_o    (c_q[k+1]),
			.ovf_o  (c_ovf[k+1]),
			.flags_o(c_flags[k+1])
		);
	end

	assign quot = c_q[LW];
	assign ovf = c_ovf[LW];
	assign flags_o = c_flags[LW];

endmodule

// ===== design/radar_measurement_jacobian.sv =====
// Top level of the radar measurement Jacobian: front stages, root and divider rows, output.
//
// Input channel: one state vector (pos_x, pos_y, vel_x, vel_y, signed fixed point)
// moves per transfer, on in_valid high with in_stall low.
// Output channel: six Jacobian entries plus too_close move per transfer, on
// out_valid high with out_stall low.
// Configuration: cfg_we writes cfg_wdata into the min-range-squared threshold;
// write only while the pipeline holds no item.
// Throughput: one transfer per cycle while in_stall is low. An item runs from
// input transfer to out_valid through four front stages, the square-root row
// of DATA_WIDTH cells, two product stages, a setup stage and a row of
// DATA_WIDTH cells in each divider lane, the saturation stage and the output
// register.
// Stall: the output register and one skid register absorb a stalled result;
// while the skid holds an item the whole pipeline holds and in_stall is high.
// Reset: clears all valid flags and restores the threshold to about 1e-6.
// Items closer than the threshold, or at zero range, report zeros.
module radar_measurement_jacobian #(
	parameter int DATA_WIDTH = rmj_pkg::RMJ_DATA_WIDTH,
	parameter int FRAC_BITS = rmj_pkg::RMJ_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [rmj_pkg::RMJ_THRESH_WIDTH-1:0] cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [DATA_WIDTH-1:0]         pos_x,
	input  logic signed [DATA_WIDTH-1:0]         pos_y,
	input  logic signed [DATA_WIDTH-1:0]         vel_x,
	input  logic signed [DATA_WIDTH-1:0]         vel_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [DATA_WIDTH-1:0]         drange_dpx,
	output logic signed [DATA_WIDTH-1:0]         drange_dpy,
	output logic signed [DATA_WIDTH-1:0]         dbearing_dpx,
	output logic signed [DATA_WIDTH-1:0]         dbearing_dpy,
	output logic signed [DATA_WIDTH-1:0]         drate_dpx,
	output logic signed [DATA_WIDTH-1:0]         drate_dpy,
	output logic                                 too_close
);
	import rmj_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam int F = FRAC_BITS;
	localparam int TW = RMJ_THRESH_WIDTH;
	localparam int CW = (2 * W > TW) ? 2 * W : TW;
	localparam int SW = 6 * W;
	// s1..s4, root row, two multiply stages, divider setup and row, saturation
	localparam int LAT = 2 * W + 8;
	localparam logic [W-1:0] ONE_W = {{(W-1){1'b0}}, 1'b1};
	localparam logic [2*W:0] ONE_X = {{(2*W){1'b0}}, 1'b1};
	localparam logic [W-1:0] SAT_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] SAT_POS = {1'b0, {(W-1){1'b1}}};

	logic          en;
	logic          in_accept;
	logic [LAT-1:0] vld_q;
	logic [TW-1:0] min_range_q;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_range_q <= RMJ_MIN_RANGE_RESET;
		end else if (cfg_we) begin
			min_range_q <= cfg_wdata;
		end
	end

	// ------------------------------------------------------------------
	// Front: magnitudes, products, squared range, cross term
	// ------------------------------------------------------------------
	logic [W-1:0] px_raw, py_raw, vx_raw, vy_raw;
	logic [W-1:0] px_abs, py_abs, vx_abs, vy_abs;

	assign px_raw = pos_x;
	assign py_raw = pos_y;
	assign vx_raw = vel_x;
	assign vy_raw = vel_y;
	assign px_abs = px_raw[W-1] ? (~px_raw + ONE_W) : px_raw;
	assign py_abs = py_raw[W-1] ? (~py_raw + ONE_W) : py_raw;
	assign vx_abs = vx_raw[W-1] ? (~vx_raw + ONE_W) : vx_raw;
	assign vy_abs = vy_raw[W-1] ? (~vy_raw + ONE_W) : vy_raw;

	logic [W-1:0] px_s1, py_s1, vx_s1, vy_s1;
	logic         pxn_s1, pyn_s1, vxn_s1, vyn_s1;

	logic [2*W-1:0] pxx_s2, pyy_s2, a_s2, b_s2;
	logic [W-1:0]   px_s2, py_s2;
	logic           pxn_s2, pyn_s2, an_s2, bn_s2;

	logic [2*W-1:0] r2_s3;
	logic [2*W:0]   cross_s3;
	logic [W-1:0]   px_s3, py_s3;
	logic           pxn_s3, pyn_s3;

	logic [2*W-1:0] r2_s4, cmag_s4;
	logic [W-1:0]   px_s4, py_s4;
	rmj_flags_t     flags_s4;

	logic [2*W:0] a_signed, b_signed, cross_abs;

	// a = vx*py with sign an; b = vy*px enters negated
	assign a_signed = an_s2 ? (~{1'b0, a_s2} + ONE_X) : {1'b0, a_s2};
	assign b_signed = bn_s2 ? {1'b0, b_s2} : (~{1'b0, b_s2} + ONE_X);
	assign cross_abs = cross_s3[2*W] ? (~cross_s3 + ONE_X) : cross_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= px_abs;
			py_s1 <= py_abs;
			vx_s1 <= vx_abs;
			vy_s1 <= vy_abs;
			pxn_s1 <= px_raw[W-1];
			pyn_s1 <= py_raw[W-1];
			vxn_s1 <= vx_raw[W-1];
			vyn_s1 <= vy_raw[W-1];

			pxx_s2 <= px_s1 * px_s1;
			pyy_s2 <= py_s1 * py_s1;
			a_s2 <= vx_s1 * py_s1;
			b_s2 <= vy_s1 * px_s1;
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			pxn_s2 <= pxn_s1;
			pyn_s2 <= pyn_s1;
			an_s2 <= vxn_s1 ^ pyn_s1;
			bn_s2 <= vyn_s1 ^ pxn_s1;

			r2_s3 <= pxx_s2 + pyy_s2;
			cross_s3 <= a_signed + b_signed;
			px_s3 <= px_s2;
			py_s3 <= py_s2;
			pxn_s3 <= pxn_s2;
			pyn_s3 <= pyn_s2;

			r2_s4 <= r2_s3;
			cmag_s4 <= cross_abs[2*W-1:0];
			px_s4 <= px_s3;
			py_s4 <= py_s3;
			flags_s4.px_neg <= pxn_s3;
			flags_s4.py_neg <= pyn_s3;
			flags_s4.cross_neg <= cross_s3[2*W];
			flags_s4.too_close <= CW'(r2_s3) < CW'(min_range_q);
			flags_s4.zero_range <= r2_s3 == '0;
		end
	end

	// ------------------------------------------------------------------
	// Square-root row: one root bit per cell
	// ------------------------------------------------------------------
	logic [W+1:0]   sq_rem   [0:W];
	logic [W-1:0]   sq_root  [0:W];
	logic [2*W-1:0] sq_val   [0:W];
	logic [SW-1:0]  sq_side  [0:W];
	rmj_flags_t     sq_flags [0:W];

	assign sq_rem[0] = '0;
	assign sq_root[0] = '0;
	assign sq_val[0] = r2_s4;
	assign sq_side[0] = {px_s4, py_s4, cmag_s4, r2_s4};
	assign sq_flags[0] = flags_s4;

	for (genvar k = 0; k < W; k++) begin : g_sqrt
		rmj_sqrt_cell #(
			.RW(W),
			.SW(SW)
		) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (sq_rem[k]),
			.root_i (sq_root[k]),
			.val_i  (sq_val[k]),
			.side_i (sq_side[k]),
			.flags_i(sq_flags[k]),
			.rem_o  (sq_rem[k+1]),
			.root_o (sq_root[k+1]),
			.val_o  (sq_val[k+1]),
			.side_o (sq_side[k+1]),
			.flags_o(sq_flags[k+1])
		);
	end

	// ------------------------------------------------------------------
	// Wide products in two halves: r2*r and p*cross
	// ------------------------------------------------------------------
	logic [W-1:0]   sq_px, sq_py;
	logic [2*W-1:0] sq_cmag, sq_r2;

	assign {sq_px, sq_py, sq_cmag, sq_r2} = sq_side[W];

	logic [2*W-1:0] den_lo_s5, den_hi_s5, pyc_lo_s5, pyc_hi_s5, pxc_lo_s5, pxc_hi_s5;
	logic [W-1:0]   px_s5, py_s5, r_s5;
	logic [2*W-1:0] r2_s5;
	rmj_flags_t     flags_s5;

	logic [3*W-1:0] den3_s6, pyc_s6, pxc_s6;
	logic [W-1:0]   px_s6, py_s6, r_s6;
	logic [2*W-1:0] r2_s6;
	rmj_flags_t     flags_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			den_lo_s5 <= sq_r2[W-1:0] * sq_root[W];
			den_hi_s5 <= sq_r2[2*W-1:W] * sq_root[W];
			pyc_lo_s5 <= sq_py * sq_cmag[W-1:0];
			pyc_hi_s5 <= sq_py * sq_cmag[2*W-1:W];
			pxc_lo_s5 <= sq_px * sq_cmag[W-1:0];
			pxc_hi_s5 <= sq_px * sq_cmag[2*W-1:W];
			px_s5 <= sq_px;
			py_s5 <= sq_py;
			r_s5 <= sq_root[W];
			r2_s5 <= sq_r2;
			flags_s5 <= sq_flags[W];

			den3_s6 <= {{W{1'b0}}, den_lo_s5} + {den_hi_s5, {W{1'b0}}};
			pyc_s6 <= {{W{1'b0}}, pyc_lo_s5} + {pyc_hi_s5, {W{1'b0}}};
			pxc_s6 <= {{W{1'b0}}, pxc_lo_s5} + {pxc_hi_s5, {W{1'b0}}};
			px_s6 <= px_s5;
			py_s6 <= py_s5;
			r_s6 <= r_s5;
			r2_s6 <= r2_s5;
			flags_s6 <= flags_s5;
		end
	end

	// ------------------------------------------------------------------
	// Divider lanes
	// ------------------------------------------------------------------
	logic [W-1:0] lane_q   [0:RMJ_LANES-1];
	logic         lane_ovf [0:RMJ_LANES-1];
	rmj_flags_t   lane_flags;

	rmj_div_lane #(.NW(W + F), .DW(W), .LW(W)) u_lane_rpx (
		.clk(clk), .en(en), .num({px_s6, {F{1'b0}}}), .den(r_s6), .flags_i(flags_s6),
		.quot(lane_q[LANE_DRANGE_DPX]), .ovf(lane_ovf[LANE_DRANGE_DPX]),
		.flags_o(lane_flags)
	);
	rmj_div_lane #(.NW(W + F), .DW(W), .LW(W)) u_lane_rpy (
		.clk(clk), .en(en), .num({py_s6, {F{1'b0}}}), .den(r_s6), .flags_i(flags_s6),
		.quot(lane_q[LANE_DRANGE_DPY]), .ovf(lane_ovf[LANE_DRANGE_DPY]), .flags_o()
	);
	rmj_div_lane #(.NW(W + 2 * F), .DW(2 * W), .LW(W)) u_lane_bpx (
		.clk(clk), .en(en), .num({py_s6, {(2*F){1'b0}}}), .den(r2_s6), .flags_i(flags_s6),
		.quot(lane_q[LANE_DBEARING_DPX]), .ovf(lane_ovf[LANE_DBEARING_DPX]), .flags_o()
	);
	rmj_div_lane #(.NW(W + 2 * F), .DW(2 * W), .LW(W)) u_lane_bpy (
		.clk(clk), .en(en), .num({px_s6, {(2*F){1'b0}}}), .den(r2_s6), .flags_i(flags_s6),
		.quot(lane_q[LANE_DBEARING_DPY]), .ovf(lane_ovf[LANE_DBEARING_DPY]), .flags_o()
	);
	rmj_div_lane #(.NW(3 * W + F), .DW(3 * W), .LW(W)) u_lane_dpx (
		.clk(clk), .en(en), .num({pyc_s6, {F{1'b0}}}), .den(den3_s6), .flags_i(flags_s6),
		.quot(lane_q[LANE_DRATE_DPX]), .ovf(lane_ovf[LANE_DRATE_DPX]), .flags_o()
	);
	rmj_div_lane #(.NW(3 * W + F), .DW(3 * W), .LW(W)) u_lane_dpy (
		.clk(clk), .en(en), .num({pxc_s6, {F{1'b0}}}), .den(den3_s6), .flags_i(flags_s6),
		.quot(lane_q[LANE_DRATE_DPY]), .ovf(lane_ovf[LANE_DRATE_DPY]), .flags_o()
	);

	// ------------------------------------------------------------------
	// Sign, saturate, zero for close or zero range
	// ------------------------------------------------------------------
	logic         lane_neg [0:RMJ_LANES-1];
	logic [W-1:0] sat_res  [0:RMJ_LANES-1];
	logic [W-1:0] res_s7   [0:RMJ_LANES-1];
	logic         close_s7;

	always_comb begin
		lane_neg[LANE_DRANGE_DPX] = lane_flags.px_neg;
		lane_neg[LANE_DRANGE_DPY] = lane_flags.py_neg;
		lane_neg[LANE_DBEARING_DPX] = !lane_flags.py_neg;
		lane_neg[LANE_DBEARING_DPY] = lane_flags.px_neg;
		lane_neg[LANE_DRATE_DPX] = lane_flags.py_neg ^ lane_flags.cross_neg;
		lane_neg[LANE_DRATE_DPY] = lane_flags.px_neg ^ !lane_flags.cross_neg;
	end

	for (genvar i = 0; i < RMJ_LANES; i++) begin : g_sat
		logic [W-1:0] lim;
		logic [W-1:0] mag;

		assign lim = lane_neg[i] ? SAT_NEG : SAT_POS;
		assign mag = (lane_ovf[i] || lane_q[i] > lim) ? lim : lane_q[i];
		assign sat_res[i] = (lane_flags.too_close || lane_flags.zero_range) ? '0 :
			(lane_neg[i] ? (~mag + ONE_W) : mag);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s7 <= sat_res;
			close_s7 <= lane_flags.too_close;
		end
	end

	// ------------------------------------------------------------------
	// Valid chain, output register and skid
	// ------------------------------------------------------------------
	logic         out_v_q;
	logic         skid_v_q;
	logic [W-1:0] out_q      [0:RMJ_LANES-1];
	logic [W-1:0] skid_q     [0:RMJ_LANES-1];
	logic         out_close_q;
	logic         skid_close_q;
	logic         last_v;

	// hold the whole pipeline while the skid is occupied
	assign en = !skid_v_q;
	assign in_stall = skid_v_q;
	assign in_accept = in_valid && !in_stall;
	assign last_v = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (en) begin
				vld_q <= {vld_q[LAT-2:0], in_accept};
			end
			if (skid_v_q) begin
				// drain the skid into the output register on transfer
				if (!out_stall) begin
					skid_v_q <= 1'b0;
				end
			end else if (last_v) begin
				if (!out_v_q || !out_stall) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (!out_stall) begin
				out_q <= skid_q;
				out_close_q <= skid_close_q;
			end
		end else if (last_v) begin
			if (!out_v_q || !out_stall) begin
				out_q <= res_s7;
				out_close_q <= close_s7;
			end else begin
				skid_q <= res_s7;
				skid_close_q <= close_s7;
			end
		end
	end

	assign out_valid = out_v_q;
	assign drange_dpx = out_q[LANE_DRANGE_DPX];
	assign drange_dpy = out_q[LANE_DRANGE_DPY];
	assign dbearing_dpx = out_q[LANE_DBEARING_DPX];
	assign dbearing_dpy = out_q[LANE_DBEARING_DPY];
	assign drate_dpx = out_q[LANE_DRATE_DPX];
	assign drate_dpy = out_q[LANE_DRATE_DPY];
	assign too_close = out_close_q;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the radar measurement Jacobian pipeline.
module tb_top;
	import rmj_pkg::*;

	localparam int DW = RMJ_DATA_WIDTH;
	localparam int FB = RMJ_FRAC_BITS;
	// Wide enough for py * cross << FRAC_BITS and for r2 * r.
	localparam int WW = 160;
	localparam int LATENCY = 2 * DW + 8;
	localparam int CYCLE_LIMIT = 1000000;

	typedef logic [RMJ_LANES-1:0][DW-1:0] lanes_t;
	typedef logic [WW-1:0] wide_t;

	typedef struct {
		logic [DW-1:0] px;
		logic [DW-1:0] py;
		logic [DW-1:0] vx;
		logic [DW-1:0] vy;
	} state_vec_t;

	typedef struct {
		lanes_t jac;
		logic   close;
	} jacobian_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [RMJ_THRESH_WIDTH-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [DW-1:0] pos_x = '0, pos_y = '0, vel_x = '0, vel_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DW-1:0] drange_dpx, drange_dpy, dbearing_dpx, dbearing_dpy;
	logic signed [DW-1:0] drate_dpx, drate_dpy;
	logic too_close;

	radar_measurement_jacobian DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y),
		.out_valid(out_valid), .out_stall(out_stall),
		.drange_dpx(drange_dpx), .drange_dpy(drange_dpy),
		.dbearing_dpx(dbearing_dpx), .dbearing_dpy(dbearing_dpy),
		.drate_dpx(drate_dpx), .drate_dpy(drate_dpy),
		.too_close(too_close)
	);

	always #1 clk = ~clk;

	// Threshold as the testbench believes it is programmed.
	logic [RMJ_THRESH_WIDTH-1:0] range_floor_sq = RMJ_MIN_RANGE_RESET;

	state_vec_t pending_states[$];
	jacobian_t  expected_jacobians[$];
	int mismatches = 0;
	int results_seen = 0;
	int close_seen = 0;
	int cycles = 0;
	bit hold_sender = 1'b0;
	bit took_input = 1'b0;

	// Magnitude of a two's complement field, so the most negative value stays exact.
	function automatic wide_t magnitude(logic [DW-1:0] x);
		logic [DW:0] e;
		e = {x[DW-1], x};
		if (x[DW-1])
			e = -e;
		return WW'(e);
	endfunction

	function automatic wide_t quotient(wide_t n, wide_t d);
		return (d == '0) ? '0 : n / d;
	endfunction

	// Clamp a sign-magnitude value into the output field.
	function automatic logic [DW-1:0] clamp(wide_t m, bit neg);
		wide_t lim;
		lim = (WW'(1) << (DW - 1)) - (neg ? WW'(0) : WW'(1));
		if (m > lim)
			m = lim;
		return neg ? DW'(-m) : DW'(m);
	endfunction

	function automatic jacobian_t jacobian_of(state_vec_t s);
		wide_t px, py, vx, vy, r2, r, cand, a, b, cm, den;
		bit pxn, pyn, an, bn, cn;
		jacobian_t o;
		pxn = s.px[DW-1];
		pyn = s.py[DW-1];
		px = magnitude(s.px);
		py = magnitude(s.py);
		vx = magnitude(s.vx);
		vy = magnitude(s.vy);
		r2 = px * px + py * py;
		o.jac = '0;
		o.close = 1'b0;
		if (r2 < WW'(range_floor_sq)) begin
			o.close = 1'b1;
			return o;
		end
		// Integer square root, floor
		r = '0;
		for (int i = DW; i >= 0; i--) begin
			cand = r | (WW'(1) << i);
			if (cand * cand <= r2)
				r = cand;
		end
		o.jac[LANE_DRANGE_DPX] = clamp(quotient(px << FB, r), pxn);
		o.jac[LANE_DRANGE_DPY] = clamp(quotient(py << FB, r), pyn);
		o.jac[LANE_DBEARING_DPX] = clamp(quotient(py << (2 * FB), r2), !pyn);
		o.jac[LANE_DBEARING_DPY] = clamp(quotient(px << (2 * FB), r2), pxn);
		// cross = vx*py - vy*px, carried as sign and magnitude
		an = s.vx[DW-1] ^ pyn;
		bn = s.vy[DW-1] ^ pxn;
		a = vx * py;
		b = vy * px;
		if (an == !bn) begin
			cm = a + b;
			cn = an;
		end else if (a >= b) begin
			cm = a - b;
			cn = an;
		end else begin
			cm = b - a;
			cn = !bn;
		end
		den = r2 * r;
		o.jac[LANE_DRATE_DPX] = clamp(quotient((py * cm) << FB, den), pyn ^ cn);
		o.jac[LANE_DRATE_DPY] = clamp(quotient((px * cm) << FB, den), pxn ^ !cn);
		return o;
	endfunction

	// Random field: mostly scaled-down values so every magnitude range shows up,
	// with the extremes mixed in.
	function automatic logic [DW-1:0] random_field();
		logic signed [DW-1:0] v;
		int pick;
		pick = $urandom_range(0, 11);
		v = $urandom;
		case (pick)
			0: return {1'b1, {(DW-1){1'b0}}};
			1: return {1'b0, {(DW-1){1'b1}}};
			2: return '0;
			3: return v;
			default: return v >>> $urandom_range(0, DW - 1);
		endcase
	endfunction

	function automatic state_vec_t random_state();
		state_vec_t s;
		s.px = random_field();
		s.py = random_field();
		s.vx = random_field();
		s.vy = random_field();
		return s;
	endfunction

	function automatic state_vec_t make_state(logic [DW-1:0] px, logic [DW-1:0] py,
			logic [DW-1:0] vx, logic [DW-1:0] vy);
		state_vec_t s;
		s.px = px;
		s.py = py;
		s.vx = vx;
		s.vy = vy;
		return s;
	endfunction

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n && (!in_valid || took_input)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (!hold_sender && pending_states.size() > 0) begin
				state_vec_t s;
				s = pending_states.pop_front();
				in_valid <= 1'b1;
				pos_x <= s.px;
				pos_y <= s.py;
				vel_x <= s.vx;
				vel_y <= s.vy;
				if (burst_left <= 0) begin
					burst_left <= $urandom_range(1, 40);
					// Sometimes no gap at all, so long back-to-back stretches occur.
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern that switches between none, random and periodic.
	int stall_mode = 0;
	int stall_phase = 0;
	always @(negedge clk) begin
		if ($urandom_range(0, 199) == 0)
			stall_mode = $urandom_range(0, 2);
		stall_phase = stall_phase + 1;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 4);
			default: out_stall <= (stall_phase % 7) < 3;
		endcase
	end

	// Input transfers: predict. Output transfers: check against the oldest prediction.
	always @(posedge clk) begin
		lanes_t got;
		jacobian_t want;
		cycles <= cycles + 1;
		took_input = arst_n && in_valid && !in_stall;
		if (took_input)
			expected_jacobians.push_back(jacobian_of(make_state(pos_x, pos_y, vel_x, vel_y)));
		if (arst_n && out_valid && !out_stall) begin
			got[LANE_DRANGE_DPX] = drange_dpx;
			got[LANE_DRANGE_DPY] = drange_dpy;
			got[LANE_DBEARING_DPX] = dbearing_dpx;
			got[LANE_DBEARING_DPY] = dbearing_dpy;
			got[LANE_DRATE_DPX] = drate_dpx;
			got[LANE_DRATE_DPY] = drate_dpy;
			results_seen <= results_seen + 1;
			if (too_close)
				close_seen <= close_seen + 1;
			if (expected_jacobians.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("ERROR: result with nothing expected at cycle %0d", cycles);
			end else begin
				want = expected_jacobians.pop_front();
				if (want.jac !== got || want.close !== too_close) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10) begin
						$display("ERROR: mismatch at cycle %0d", cycles);
						for (int k = 0; k < RMJ_LANES; k++)
							if (want.jac[k] !== got[k])
								$display("  lane %0d: expected %h got %h", k,
									want.jac[k], got[k]);
						if (want.close !== too_close)
							$display("  too_close: expected %b got %b", want.close,
								too_close);
					end
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("simulation failed");
			$finish;
		end
	end

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_states.size() != 0 || in_valid || expected_jacobians.size() != 0);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	task automatic write_threshold(logic [RMJ_THRESH_WIDTH-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		range_floor_sq = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			pending_states.push_back(random_state());
	endtask

	localparam logic [DW-1:0] MAXP = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MAXN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] ONE = DW'(1) << FB;
	localparam logic [DW-1:0] LSB = DW'(1);

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset threshold: origin and tiny vectors fall under it, extremes saturate.
		pending_states.push_back(make_state('0, '0, '0, '0));
		pending_states.push_back(make_state(LSB, '0, MAXP, MAXN));
		pending_states.push_back(make_state(ONE, '0, '0, '0));
		pending_states.push_back(make_state('0, ONE, ONE, '0));
		pending_states.push_back(make_state(-ONE, -ONE, ONE, -ONE));
		pending_states.push_back(make_state(MAXP, MAXP, MAXP, MAXP));
		pending_states.push_back(make_state(MAXN, MAXN, MAXN, MAXN));
		pending_states.push_back(make_state(MAXP, MAXN, MAXN, MAXP));
		pending_states.push_back(make_state(MAXN, MAXP, MAXP, MAXN));
		pending_states.push_back(make_state(DW'(256), DW'(1), MAXP, MAXN));
		pending_states.push_back(make_state(DW'(1), DW'(300), MAXN, MAXN));
		pending_states.push_back(make_state(DW'(66), DW'(0), '0, '0));
		pending_states.push_back(make_state(DW'(65), DW'(0), '0, '0));
		pending_states.push_back(make_state(ONE, ONE, ONE, ONE));
		pending_states.push_back(make_state(-ONE, ONE, -ONE, ONE));
		pending_states.push_back(make_state('1, '1, '1, '1));
		queue_random(600);
		wait_idle();

		// Zero threshold: zero range gives zeros without the flag.
		write_threshold('0);
		pending_states.push_back(make_state('0, '0, '0, '0));
		pending_states.push_back(make_state('0, '0, MAXN, MAXP));
		pending_states.push_back(make_state(LSB, '0, MAXN, MAXP));
		pending_states.push_back(make_state('0, -LSB, MAXP, MAXP));
		queue_random(400);
		wait_idle();

		// Largest threshold: everything is too close.
		write_threshold('1);
		pending_states.push_back(make_state(MAXN, MAXN, MAXP, MAXP));
		queue_random(100);
		wait_idle();

		// Mid threshold around one unit of range, with a pause until drained.
		write_threshold(64'h1_0000_0000);
		pending_states.push_back(make_state(ONE, '0, '0, '0));
		pending_states.push_back(make_state(ONE - LSB, '0, '0, '0));
		queue_random(250);
		hold_sender = 1'b1;
		while (expected_jacobians.size() != 0 || in_valid)
			@(posedge clk);
		hold_sender = 1'b0;
		queue_random(250);
		wait_idle();

		// Back to the reset value.
		write_threshold(RMJ_MIN_RANGE_RESET);
		queue_random(300);
		wait_idle();

		$display("Checked %0d Jacobian results (%0d too close) over five threshold settings",
			results_seen, close_seen);
		$display("with random bursts, gaps and output stalls; %0d mismatches.", mismatches);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== radar_measurement_jacobian.f =====
design/rmj_pkg.sv
design/rmj_sqrt_cell.sv
design/rmj_div_cell.sv
design/rmj_div_lane.sv
design/radar_measurement_jacobian.sv
verif/tb_top.sv
